### rtl/core/sfpm_pkg.sv
// Shared types, constants and the microcode table of the stereo frame pair matcher.
// Used by sfpm_useq, sfpm_dpath, the top level and its checker. No dependencies.
package sfpm_pkg;

	// Field widths of the event and result beats
	localparam int TIME_W      = 32;
	localparam int PERIOD_W    = 16;
	localparam int DROP_W      = 2;
	localparam int TIME_BITS_DEF = 32;

	// Match window: gap_ms <= (pL + pR) / 16 / 4, periods are in 1/16 ms
	localparam int MATCH_SHIFT = 6;

	// Match loop: at most three check passes per event
	localparam int PASS_W      = 2;
	localparam logic [PASS_W-1:0] MAX_PASS = 2'd3;

	typedef struct packed {
		logic                side;
		logic [TIME_W-1:0]   frame_time;
		logic [PERIOD_W-1:0] frame_period;
		logic                other_started;
		logic [TIME_W-1:0]   other_start_time;
	} evt_t;

	typedef struct packed {
		logic                parked;
		logic                pair_valid;
		logic [TIME_W-1:0]   left_time;
		logic [TIME_W-1:0]   right_time;
		logic [TIME_W-1:0]   pair_time;
		logic [DROP_W-1:0]   dropped_count;
		logic                hold_promoted;
	} res_t;

	// Micro-operations driven into the datapath
	typedef enum logic [2:0] {
		UOP_WAIT    = 3'd0,  // take an event beat
		UOP_DIST    = 3'd1,  // distances of slot frame and new frame to other start
		UOP_PLACE   = 3'd2,  // store new frame in side slot or hold slot
		UOP_DIFF    = 3'd3,  // order, gap and window of the two slots
		UOP_RESOLVE = 3'd4,  // emit pair or drop older frame
		UOP_PROMO   = 3'd5,  // move held frame into an emptied slot
		UOP_NOP     = 3'd6,
		UOP_OUT     = 3'd7   // load result register
	} uop_t;

	// Jump conditions
	typedef enum logic [2:0] {
		COND_NEVER     = 3'd0,
		COND_NO_EVT    = 3'd1,
		COND_NOT_BOTH  = 3'd2,
		COND_MORE_PASS = 3'd3,
		COND_OUT_BUSY  = 3'd4
	} cond_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_WAIT    = 3'd0;
	localparam step_t STEP_DIST    = 3'd1;
	localparam step_t STEP_PLACE   = 3'd2;
	localparam step_t STEP_TEST    = 3'd3;
	localparam step_t STEP_RESOLVE = 3'd4;
	localparam step_t STEP_PROMO   = 3'd5;
	localparam step_t STEP_LOOP    = 3'd6;
	localparam step_t STEP_OUT     = 3'd7;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} ucode_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic both_valid;
		logic out_free;
	} stat_t;

	// Control store: jump to target when cond holds, else go to the next step.
	// The last step wraps to the first.
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t cw;
		unique case (step)
			STEP_WAIT:    cw = '{UOP_WAIT,    COND_NO_EVT,    STEP_WAIT};
			STEP_DIST:    cw = '{UOP_DIST,    COND_NEVER,     STEP_WAIT};
			STEP_PLACE:   cw = '{UOP_PLACE,   COND_NEVER,     STEP_WAIT};
			STEP_TEST:    cw = '{UOP_DIFF,    COND_NOT_BOTH,  STEP_OUT};
			STEP_RESOLVE: cw = '{UOP_RESOLVE, COND_NEVER,     STEP_WAIT};
			STEP_PROMO:   cw = '{UOP_PROMO,   COND_NEVER,     STEP_WAIT};
			STEP_LOOP:    cw = '{UOP_NOP,     COND_MORE_PASS, STEP_TEST};
			STEP_OUT:     cw = '{UOP_OUT,     COND_OUT_BUSY,  STEP_OUT};
		endcase
		return cw;
	endfunction

endpackage

### rtl/core/stereo_frame_pair_matcher.sv
// Top level of the stereo frame pair matcher: sequencer plus datapath.
// Depends on sfpm_pkg, sfpm_useq and sfpm_dpath.
//
// Usage:
//   evt channel (evt_valid/evt_ready/evt): one frame-ready event per beat,
//   from the left or right camera, with the other camera's start state.
//   res channel (res_valid/res_ready/res): exactly one result beat per event,
//   in event order: where the frame was stored, an optional matched pair
//   with its midpoint time, the number of dropped frames and hold promotion.
// Timing: the microcode sequencer handles one event at a time. After the
//   event beat is accepted it runs the distance, place and test steps,
//   then for each check pass the resolve, promote and loop steps, back to
//   test, and finally the output step (the hold slot refills only once,
//   so a third pass never happens). evt_ready is high only while the
//   sequencer sits on its wait step, which it enters in the cycle after
//   the result is loaded.
// Reset: arst_n clears all slot and hold valid bits, the step counter and
//   res_valid. Stored times are not reset; nothing is paired until refilled.
// Stall: the result register holds its beat until res_ready. A new event
//   is accepted meanwhile and worked on; the sequencer then waits at its
//   output step until the result register is free.
module stereo_frame_pair_matcher #(
	parameter int TIME_BITS = sfpm_pkg::TIME_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           evt_valid,
	output logic           evt_ready,
	input  sfpm_pkg::evt_t evt,
	output logic           res_valid,
	input  logic           res_ready,
	output sfpm_pkg::res_t res
);

	sfpm_pkg::ucode_t ctrl;
	sfpm_pkg::stat_t  stat;
	logic             evt_fire;

	assign evt_ready = (ctrl.op == sfpm_pkg::UOP_WAIT);
	assign evt_fire  = evt_valid && evt_ready;

	sfpm_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	sfpm_dpath #(
		.TIME_BITS (TIME_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.evt       (evt),
		.evt_fire  (evt_fire),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res),
		.stat      (stat)
	);

endmodule

### rtl/core/sfpm_useq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on sfpm_pkg.
module sfpm_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             evt_valid,
	input  sfpm_pkg::stat_t  stat,
	output sfpm_pkg::ucode_t ctrl
);

	sfpm_pkg::step_t                  step_q;
	sfpm_pkg::step_t                  step_nxt;
	logic [sfpm_pkg::PASS_W-1:0]      pass_q;
	logic                             jump;

	assign ctrl = sfpm_pkg::ucode_rom(step_q);

	// Condition select
	always_comb begin
		unique case (ctrl.cond)
			sfpm_pkg::COND_NEVER:     jump = 1'b0;
			sfpm_pkg::COND_NO_EVT:    jump = !evt_valid;
			sfpm_pkg::COND_NOT_BOTH:  jump = !stat.both_valid;
			sfpm_pkg::COND_MORE_PASS: jump = (pass_q < sfpm_pkg::MAX_PASS);
			sfpm_pkg::COND_OUT_BUSY:  jump = !stat.out_free;
			default:                  jump = 1'b0;
		endcase
		step_nxt = jump ? ctrl.target : sfpm_pkg::step_t'(step_q + 3'd1);
	end

	// Step counter and pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sfpm_pkg::STEP_WAIT;
			pass_q <= '0;
		end else begin
			step_q <= step_nxt;
			if (ctrl.op == sfpm_pkg::UOP_WAIT) begin
				pass_q <= '0;
			end else if (ctrl.op == sfpm_pkg::UOP_PROMO) begin
				pass_q <= pass_q + sfpm_pkg::PASS_W'(1);
			end
		end
	end

endmodule

### rtl/core/sfpm_dpath.sv
// Datapath: side slots, hold slot, distance and match arithmetic, result register.
// Driven by sfpm_useq control words. Depends on sfpm_pkg.
module sfpm_dpath #(
	parameter int TIME_BITS = sfpm_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sfpm_pkg::ucode_t ctrl,
	input  sfpm_pkg::evt_t   evt,
	input  logic             evt_fire,
	input  logic             res_ready,
	output logic             res_valid,
	output sfpm_pkg::res_t   res,
	output sfpm_pkg::stat_t  stat
);

	localparam int PW      = sfpm_pkg::PERIOD_W;
	localparam int LIMIT_W = PW + 1 - sfpm_pkg::MATCH_SHIFT;

	// Captured event
	logic                 side_q;
	logic [TIME_BITS-1:0] t_q;
	logic [PW-1:0]        per_q;
	logic                 other_on_q;
	logic [TIME_BITS-1:0] ot_q;

	// Slots
	logic [1:0]           slot_vld_q;
	logic [TIME_BITS-1:0] slot_time_q [2];
	logic [PW-1:0]        slot_per_q [2];
	logic                 hold_vld_q;
	logic                 hold_side_q;
	logic [TIME_BITS-1:0] hold_time_q;
	logic [PW-1:0]        hold_per_q;

	// Working registers
	logic [TIME_BITS-1:0] gap_slot_q;
	logic [TIME_BITS-1:0] gap_new_q;
	logic [TIME_BITS-1:0] lo_q;
	logic [TIME_BITS-1:0] diff_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic                 l_gt_r_q;

	// Result accumulators
	logic                       parked_q;
	logic                       pv_q;
	logic [TIME_BITS-1:0]       lt_q;
	logic [TIME_BITS-1:0]       rt_q;
	logic [TIME_BITS-1:0]       pt_q;
	logic [sfpm_pkg::DROP_W-1:0] drops_q;
	logic                       promo_q;

	logic                 res_valid_q;
	sfpm_pkg::res_t       res_q;

	// Combinational terms
	logic [TIME_BITS-1:0] slot_cur_time;
	logic [TIME_BITS-1:0] gap_slot;
	logic [TIME_BITS-1:0] gap_new;
	logic                 take;
	logic                 t0_lt_t1;
	logic [PW:0]          per_sum;
	logic                 match;
	logic                 promote;
	logic                 out_free;

	assign slot_cur_time = slot_time_q[side_q];

	// Absolute distances to the other camera's start time
	assign gap_slot = (slot_cur_time > ot_q) ? (slot_cur_time - ot_q) : (ot_q - slot_cur_time);
	assign gap_new  = (t_q > ot_q) ? (t_q - ot_q) : (ot_q - t_q);

	// New frame wins unless other started and a valid slot frame is no farther
	assign take = !slot_vld_q[side_q] || !other_on_q || (gap_slot_q > gap_new_q);

	assign t0_lt_t1 = slot_time_q[0] < slot_time_q[1];
	assign per_sum  = {1'b0, slot_per_q[0]} + {1'b0, slot_per_q[1]};
	assign match    = diff_q <= TIME_BITS'(limit_q);
	assign promote  = hold_vld_q && !slot_vld_q[hold_side_q];
	assign out_free = !res_valid_q || res_ready;

	assign stat.both_valid = slot_vld_q[0] && slot_vld_q[1];
	assign stat.out_free   = out_free;

	// Valid bits and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q  <= '0;
			hold_vld_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				sfpm_pkg::UOP_PLACE: begin
					if (take) begin
						slot_vld_q[side_q] <= 1'b1;
					end else begin
						hold_vld_q <= 1'b1;
					end
				end
				sfpm_pkg::UOP_RESOLVE: begin
					if (match) begin
						slot_vld_q <= '0;
					end else if (l_gt_r_q) begin
						slot_vld_q[1] <= 1'b0;
					end else begin
						slot_vld_q[0] <= 1'b0;
					end
				end
				sfpm_pkg::UOP_PROMO: begin
					if (promote) begin
						hold_vld_q               <= 1'b0;
						slot_vld_q[hold_side_q]  <= 1'b1;
					end
				end
				default: ;
			endcase
			if (ctrl.op == sfpm_pkg::UOP_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (evt_fire) begin
			side_q     <= evt.side;
			t_q        <= TIME_BITS'(evt.frame_time);
			per_q      <= evt.frame_period;
			other_on_q <= evt.other_started;
			ot_q       <= TIME_BITS'(evt.other_start_time);
			parked_q   <= 1'b0;
			pv_q       <= 1'b0;
			lt_q       <= '0;
			rt_q       <= '0;
			pt_q       <= '0;
			drops_q    <= '0;
			promo_q    <= 1'b0;
		end
		unique case (ctrl.op)
			sfpm_pkg::UOP_DIST: begin
				gap_slot_q <= gap_slot;
				gap_new_q  <= gap_new;
			end
			sfpm_pkg::UOP_PLACE: begin
				if (take) begin
					slot_time_q[side_q] <= t_q;
					slot_per_q[side_q]  <= per_q;
				end else begin
					parked_q    <= 1'b1;
					hold_side_q <= side_q;
					hold_time_q <= t_q;
					hold_per_q  <= per_q;
				end
			end
			sfpm_pkg::UOP_DIFF: begin
				lo_q     <= t0_lt_t1 ? slot_time_q[0] : slot_time_q[1];
				diff_q   <= t0_lt_t1 ? (slot_time_q[1] - slot_time_q[0])
				                     : (slot_time_q[0] - slot_time_q[1]);
				limit_q  <= per_sum[PW:sfpm_pkg::MATCH_SHIFT];
				l_gt_r_q <= slot_time_q[0] > slot_time_q[1];
			end
			sfpm_pkg::UOP_RESOLVE: begin
				if (match) begin
					pv_q <= 1'b1;
					lt_q <= slot_time_q[0];
					rt_q <= slot_time_q[1];
					pt_q <= lo_q + (diff_q >> 1);
				end else begin
					drops_q <= drops_q + sfpm_pkg::DROP_W'(1);
				end
			end
			sfpm_pkg::UOP_PROMO: begin
				if (promote) begin
					slot_time_q[hold_side_q] <= hold_time_q;
					slot_per_q[hold_side_q]  <= hold_per_q;
					promo_q                  <= 1'b1;
				end
			end
			sfpm_pkg::UOP_OUT: begin
				if (out_free) begin
					res_q.parked        <= parked_q;
					res_q.pair_valid    <= pv_q;
					res_q.left_time     <= sfpm_pkg::TIME_W'(lt_q);
					res_q.right_time    <= sfpm_pkg::TIME_W'(rt_q);
					res_q.pair_time     <= sfpm_pkg::TIME_W'(pt_q);
					res_q.dropped_count <= drops_q;
					res_q.hold_promoted <= promo_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/core/sfpm_checker.sv
// Port-level checks of the stereo frame pair matcher, bound to the top level.
// Depends on sfpm_pkg and stereo_frame_pair_matcher.
module sfpm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           evt_valid,
	input logic           evt_ready,
	input logic           res_valid,
	input logic           res_ready,
	input sfpm_pkg::res_t res
);

	// A stalled result beat stays up
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat withdrawn while stalled");

	// A stalled result beat keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result payload changed while stalled");

	// One event at a time: ready drops right after an accepted beat
	a_evt_one: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
		else $error("event accepted while previous event in progress");

	// Without a pair, all pair times read zero
	a_no_pair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.pair_valid |-> res.left_time == '0 &&
		res.right_time == '0 && res.pair_time == '0)
		else $error("pair times nonzero without a pair");

	// The hold slot refills once, so at most two drops per event
	a_drop_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.dropped_count != 2'd3)
		else $error("more than two frames dropped in one event");

endmodule

bind stereo_frame_pair_matcher sfpm_checker u_sfpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt_valid),
	.evt_ready (evt_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

### test/tb_stereo_frame_pair_matcher.sv
// Testbench of stereo_frame_pair_matcher: directed and random frame events, a slot and hold
// predictor, and beat-by-beat checks of results under several idle and stall phases.
// Depends on sfpm_pkg and the RTL top level stereo_frame_pair_matcher.
module tb_stereo_frame_pair_matcher;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYC   = 8;
	localparam int DRAIN_CYC   = 20;
	localparam int LIMIT_CYC   = 1000000;
	localparam int SHOW_FAULTS = 10;

	localparam logic SIDE_LEFT  = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_ready;
	sfpm_pkg::evt_t evt = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	sfpm_pkg::res_t res;

	// Pending event beats and the results they should produce
	sfpm_pkg::evt_t pend_q[$];
	sfpm_pkg::res_t exp_res_q[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fault_cnt = 0;

	// Predictor state: one slot per camera and one hold slot
	logic        slot_full[2];
	logic [31:0] slot_ts[2];
	logic [15:0] slot_per[2];
	logic        held_full;
	logic        held_side;
	logic [31:0] held_ts;
	logic [15:0] held_per;

	stereo_frame_pair_matcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#(2 * CLK_HALF * LIMIT_CYC);
		$display("stereo_frame_pair_matcher verification failed");
		$finish;
	end

	function automatic logic [31:0] time_gap(logic [31:0] a, logic [31:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Place the new frame, then run the check loop over both slots
	function automatic sfpm_pkg::res_t match_frame_event(sfpm_pkg::evt_t e);
		sfpm_pkg::res_t r;
		logic take;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [16:0] win;
		int pass;
		r = '0;
		take = !slot_full[e.side] || !e.other_started ||
			time_gap(slot_ts[e.side], e.other_start_time) >
			time_gap(e.frame_time, e.other_start_time);
		if (take) begin
			slot_full[e.side] = 1'b1;
			slot_ts[e.side] = e.frame_time;
			slot_per[e.side] = e.frame_period;
		end else begin
			r.parked = 1'b1;
			held_full = 1'b1;
			held_side = e.side;
			held_ts = e.frame_time;
			held_per = e.frame_period;
		end
		pass = 0;
		while (pass < 3 && slot_full[0] && slot_full[1]) begin
			lo = (slot_ts[0] < slot_ts[1]) ? slot_ts[0] : slot_ts[1];
			hi = (slot_ts[0] < slot_ts[1]) ? slot_ts[1] : slot_ts[0];
			win = ({1'b0, slot_per[0]} + {1'b0, slot_per[1]}) >> sfpm_pkg::MATCH_SHIFT;
			if (hi - lo <= {15'd0, win}) begin
				r.pair_valid = 1'b1;
				r.left_time = slot_ts[0];
				r.right_time = slot_ts[1];
				r.pair_time = lo + ((hi - lo) >> 1);
				slot_full[0] = 1'b0;
				slot_full[1] = 1'b0;
			end else if (slot_ts[0] > slot_ts[1]) begin
				slot_full[1] = 1'b0;
				r.dropped_count = r.dropped_count + 2'd1;
			end else begin
				slot_full[0] = 1'b0;
				r.dropped_count = r.dropped_count + 2'd1;
			end
			// held frame refills its emptied slot
			if (held_full && !slot_full[held_side]) begin
				held_full = 1'b0;
				slot_full[held_side] = 1'b1;
				slot_ts[held_side] = held_ts;
				slot_per[held_side] = held_per;
				r.hold_promoted = 1'b1;
			end
			pass++;
		end
		return r;
	endfunction

	function automatic sfpm_pkg::evt_t frame_evt(logic sd, logic [31:0] t, logic [15:0] p,
		logic os, logic [31:0] ot);
		sfpm_pkg::evt_t e;
		e.side = sd;
		e.frame_time = t;
		e.frame_period = p;
		e.other_started = os;
		e.other_start_time = ot;
		return e;
	endfunction

	// Mostly camera-like timelines with close left/right times, the rest raw noise
	task automatic queue_random_events(int n);
		logic [31:0] tl_now;
		logic [15:0] tl_per;
		logic sd;
		logic os;
		tl_now = $urandom;
		tl_per = 16'($urandom_range(400, 2200));
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				if ($urandom_range(3) == 0)
					tl_now = $urandom;
				case ($urandom_range(7))
					0: tl_per = 16'd0;
					1: tl_per = 16'hFFFF;
					default: tl_per = 16'($urandom_range(400, 2200));
				endcase
			end
			sd = 1'($urandom_range(1));
			os = 1'($urandom_range(1));
			if ($urandom_range(99) < 25) begin
				pend_q.push_back(frame_evt(sd, $urandom, 16'($urandom_range(65535)),
					os, $urandom));
			end else begin
				tl_now = tl_now + 32'($urandom_range(60));
				pend_q.push_back(frame_evt(sd, tl_now + 32'($urandom_range(40)),
					tl_per + 16'($urandom_range(64)), os,
					tl_now + 32'($urandom_range(40))));
			end
		end
	endtask

	// Hold the sender until every expected beat is back
	task automatic wait_drained();
		while (pend_q.size() != 0 || evt_valid || exp_res_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic note_fault(string what, logic [31:0] want_v, logic [31:0] got_v);
		fault_cnt++;
		if (fault_cnt <= SHOW_FAULTS)
			$display("mismatch %0s: expected %h, got %h", what, want_v, got_v);
	endtask

	task automatic cmp_field(string what, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v)
			note_fault(what, want_v, got_v);
	endtask

	// Event driver: load the next beat once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid <= 1'b0;
		end else begin
			if (evt_valid && evt_ready)
				exp_res_q.push_back(match_frame_event(evt));
			if (!evt_valid || evt_ready) begin
				if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					evt <= pend_q.pop_front();
					evt_valid <= 1'b1;
				end else begin
					evt_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Result monitor
	always @(posedge clk) begin : result_monitor
		sfpm_pkg::res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (exp_res_q.size() == 0) begin
				note_fault("unexpected result beat", 32'd0, 32'd0);
			end else begin
				want = exp_res_q.pop_front();
				cmp_field("parked", 32'(want.parked), 32'(res.parked));
				cmp_field("pair_valid", 32'(want.pair_valid), 32'(res.pair_valid));
				cmp_field("left_time", want.left_time, res.left_time);
				cmp_field("right_time", want.right_time, res.right_time);
				cmp_field("pair_time", want.pair_time, res.pair_time);
				cmp_field("dropped_count", 32'(want.dropped_count),
					32'(res.dropped_count));
				cmp_field("hold_promoted", 32'(want.hold_promoted),
					32'(res.hold_promoted));
			end
		end
	end

	initial begin
		for (int s = 0; s < 2; s++) begin
			slot_full[s] = 1'b0;
			slot_ts[s] = '0;
			slot_per[s] = '0;
		end
		held_full = 1'b0;
		held_side = 1'b0;
		held_ts = '0;
		held_per = '0;

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: equal times, window edge, drops both ways, tie, hold overwrite
		pend_q.push_back(frame_evt(SIDE_LEFT, 32'd1000, 16'd1067, 1'b0, 32'd0));
		pend_q.push_back(frame_evt(SIDE_RIGHT, 32'd1000, 16'd1067, 1'b1, 32'd1000));
		pend_q.push_back(frame_evt(SIDE_LEFT, 32'd2000, 16'd640, 1'b0, 32'd0));
		pend_q.push_back(frame_evt(SIDE_RIGHT, 32'd2020, 16'd640, 1'b1, 32'd2000));
		pend_q.push_back(frame_evt(SIDE_LEFT, 32'd3000, 16'd640, 1'b0, 32'd0));
		pend_q.push_back(frame_evt(SIDE_RIGHT, 32'd3021, 16'd640, 1'b0, 32'd0));
		pend_q.push_back(frame_evt(SIDE_LEFT, 32'd5000, 16'd0, 1'b1, 32'd4000));
		pend_q.push_back(frame_evt(SIDE_LEFT, 32'd6000, 16'd0, 1'b1, 32'd5500));
		pend_q.push_back(frame_evt(SIDE_LEFT, 32'd4000, 16'd16, 1'b1, 32'd5500));
		pend_q.push_back(frame_evt(SIDE_RIGHT, 32'd4100, 16'hFFFF, 1'b1, 32'd4000));
		pend_q.push_back(frame_evt(SIDE_RIGHT, 32'd4000, 16'd0, 1'b0, 32'd0));
		// Extremes of time and period
		pend_q.push_back(frame_evt(SIDE_LEFT, 32'd0, 16'hFFFF, 1'b0, 32'hFFFF_FFFF));
		pend_q.push_back(frame_evt(SIDE_RIGHT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
			32'hFFFF_FFFF));
		pend_q.push_back(frame_evt(SIDE_LEFT, 32'hFFFF_FFFF, 16'd0, 1'b1, 32'd0));
		// Two drops in one event with a promotion between them
		pend_q.push_back(frame_evt(SIDE_LEFT, 32'd100, 16'd0, 1'b0, 32'd0));
		pend_q.push_back(frame_evt(SIDE_RIGHT, 32'd200, 16'd0, 1'b1, 32'd200));
		pend_q.push_back(frame_evt(SIDE_RIGHT, 32'd300, 16'd0, 1'b1, 32'd50));
		pend_q.push_back(frame_evt(SIDE_LEFT, 32'd500, 16'd0, 1'b0, 32'd0));
		pend_q.push_back(frame_evt(SIDE_RIGHT, 32'd500, 16'd32, 1'b0, 32'd0));

		// Phase: no idling
		queue_random_events(450);
		wait_drained();

		// Phase: sender mostly idle
		send_idle_pct = 79;
		recv_stall_pct = 0;
		queue_random_events(450);
		wait_drained();

		// Phase: receiver mostly stalling
		send_idle_pct = 0;
		recv_stall_pct = 79;
		queue_random_events(450);
		wait_drained();

		// Phase: light idling on both sides
		send_idle_pct = 16;
		recv_stall_pct = 16;
		queue_random_events(400);
		wait_drained();

		if (fault_cnt == 0 && exp_res_q.size() == 0) begin
			$display("stereo_frame_pair_matcher verification clean");
		end else begin
			$display("stereo_frame_pair_matcher verification failed");
		end
		$finish;
	end

endmodule
